### rtl/pbahrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbahrs_pkg
// Shared types and constants of the per-bin attack/hold/release smoother.
// ----------------------------------------------------------------------------
package pbahrs_pkg;

  localparam logic [8:0]  COEF_ONE           = 9'd256;
  localparam logic [8:0]  LEVEL_COEFF_RESET  = 9'd77;
  localparam logic [8:0]  ATTACK_COEFF_RESET = 9'd179;
  localparam logic [8:0]  RELEASE_COEFF_RESET = 9'd51;
  localparam logic [15:0] HOLD_TICKS_RESET   = 16'd40;

  typedef enum logic [1:0] {
    PHASE_LOAD    = 2'd0,
    PHASE_ATTACK  = 2'd1,
    PHASE_HOLD    = 2'd2,
    PHASE_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_LEVEL_COEFF   = 2'd0,
    REG_ATTACK_COEFF  = 2'd1,
    REG_RELEASE_COEFF = 2'd2,
    REG_HOLD_TICKS    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0]  level_coeff;
    logic [8:0]  attack_coeff;
    logic [8:0]  release_coeff;
    logic [15:0] hold_ticks;
  } cfg_t;

  function automatic logic [8:0] clamp_coef(logic [8:0] c);
    return (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

endpackage

### rtl/pbahrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbahrs_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module pbahrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/pbahrs_ema.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbahrs_ema
// One EMA step: old + round((x - old) * c / 256), saturated.
// ----------------------------------------------------------------------------
module pbahrs_ema #(
  parameter int VALUE_BITS = 16
) (
  input  logic signed [VALUE_BITS-1:0] old_val,
  input  logic signed [VALUE_BITS-1:0] x_val,
  input  logic        [8:0]            coef,
  output logic signed [VALUE_BITS-1:0] y_val
);

  localparam int W = VALUE_BITS + 11;
  localparam logic signed [W-1:0] HALF = W'(128);
  localparam logic signed [W-1:0] HI = {{(W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] LO = {{(W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

  logic signed [W-1:0] diff;
  logic signed [W-1:0] coef_s;
  logic signed [W-1:0] prod;
  logic signed [W-1:0] delta;
  logic signed [W-1:0] sum;

  always_comb begin
    diff   = W'(x_val) - W'(old_val);
    coef_s = W'({1'b0, coef});
    prod   = diff * coef_s;
    delta  = (prod + HALF) >>> 8;
    sum    = W'(old_val) + delta;
    if (sum > HI) begin
      y_val = VALUE_BITS'(HI);
    end else if (sum < LO) begin
      y_val = VALUE_BITS'(LO);
    end else begin
      y_val = VALUE_BITS'(sum);
    end
  end

endmodule

### rtl/pbahrs_bin_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbahrs_bin_update
// Read-modify-write datapath for one bin: load, attack, hold or release.
// ----------------------------------------------------------------------------
module pbahrs_bin_update #(
  parameter int VALUE_BITS = 16
) (
  input  pbahrs_pkg::cfg_t             cfg,
  input  logic                         old_valid,
  input  logic signed [VALUE_BITS-1:0] old_level,
  input  logic signed [VALUE_BITS-1:0] old_reduction,
  input  logic        [31:0]           old_deadline,
  input  logic signed [VALUE_BITS-1:0] new_level_in,
  input  logic signed [VALUE_BITS-1:0] new_reduction_in,
  input  logic        [31:0]           now,
  input  logic                         reload,
  output logic signed [VALUE_BITS-1:0] level_next,
  output logic signed [VALUE_BITS-1:0] reduction_next,
  output logic        [31:0]           deadline_next,
  output pbahrs_pkg::phase_t           phase_next
);

  logic signed [VALUE_BITS-1:0] level_ema;
  logic signed [VALUE_BITS-1:0] attack_ema;
  logic signed [VALUE_BITS-1:0] release_ema;
  logic        [VALUE_BITS-1:0] mag_new;
  logic        [VALUE_BITS-1:0] mag_old;
  logic        [31:0]           remain;
  logic                         holding;

  pbahrs_ema #(.VALUE_BITS(VALUE_BITS)) u_level_ema (
    .old_val (old_level),
    .x_val   (new_level_in),
    .coef    (cfg.level_coeff),
    .y_val   (level_ema)
  );

  pbahrs_ema #(.VALUE_BITS(VALUE_BITS)) u_attack_ema (
    .old_val (old_reduction),
    .x_val   (new_reduction_in),
    .coef    (cfg.attack_coeff),
    .y_val   (attack_ema)
  );

  pbahrs_ema #(.VALUE_BITS(VALUE_BITS)) u_release_ema (
    .old_val (old_reduction),
    .x_val   (new_reduction_in),
    .coef    (cfg.release_coeff),
    .y_val   (release_ema)
  );

  always_comb begin
    mag_new = new_reduction_in[VALUE_BITS-1] ? (~new_reduction_in + 1'b1) : new_reduction_in;
    mag_old = old_reduction[VALUE_BITS-1] ? (~old_reduction + 1'b1) : old_reduction;
    remain  = old_deadline - now;
    holding = (remain != 32'd0) && !remain[31];

    level_next     = level_ema;
    reduction_next = old_reduction;
    deadline_next  = old_deadline;
    phase_next     = pbahrs_pkg::PHASE_HOLD;

    if (reload || !old_valid) begin
      level_next     = new_level_in;
      reduction_next = new_reduction_in;
      deadline_next  = now;
      phase_next     = pbahrs_pkg::PHASE_LOAD;
    end else if (mag_new > mag_old) begin
      reduction_next = attack_ema;
      deadline_next  = now + 32'(cfg.hold_ticks);
      phase_next     = pbahrs_pkg::PHASE_ATTACK;
    end else if (!holding) begin
      reduction_next = release_ema;
      phase_next     = pbahrs_pkg::PHASE_RELEASE;
    end
  end

endmodule

### rtl/per_bin_attack_hold_release_smoother_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_bin_attack_hold_release_smoother_unit
// Per-bin level EMA and attack/hold/release reduction smoother.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (item_valid/item_stall) carry one spectrum bin each; every
//   item yields exactly one result item (result_valid/result_stall).
//   Throughput is one item per cycle while item_stall is low. Stage 1
//   reduces the bin index modulo NUM_BINS and issues the RAM read,
//   stage 2 takes the bin's RAM word, updates it, writes it back and loads
//   the output register. Back-to-back items on the same bin are forwarded.
//   The per-bin state lives in one RAM with a single write and a single read
//   port, which sets the one-item-per-cycle rate.
//   After reset the RAM is swept clean bin by bin with item_stall high;
//   configuration writes are taken during that time. cfg_ready is always
//   high; write only while no item is in flight.
//   When result_stall is high the result holds and the pipeline keeps
//   filling its empty stages, then item_stall rises.
// ----------------------------------------------------------------------------
module per_bin_attack_hold_release_smoother_unit #(
  parameter int NUM_BINS   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [9:0]         bin_index,
  input  logic signed [15:0] level_db,
  input  logic signed [15:0] reduction_db,
  input  logic [31:0]        now_ticks,
  input  logic               reload,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [9:0]         out_bin,
  output logic signed [15:0] smooth_level_db,
  output logic signed [15:0] smooth_reduction_db,
  output logic [1:0]         phase,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int WORD_W = 2 * VALUE_BITS + 33;
  localparam logic [23:0] BIN_RECIP = 24'((2**24 + NUM_BINS - 1) / NUM_BINS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  pbahrs_pkg::cfg_t cfg;

  logic             clear_active;
  logic [BIN_W-1:0] clear_addr;

  logic s1_valid, s2_valid, res_valid;
  logic s1_move, s2_move, s1_free, s2_free, res_free;
  logic accept;

  logic [33:0] q_prod;

  logic [9:0]                   s1_x;
  logic [9:0]                   s1_q;
  logic signed [VALUE_BITS-1:0] s1_lvl;
  logic signed [VALUE_BITS-1:0] s1_red;
  logic [31:0]                  s1_now;
  logic                         s1_reload;
  logic [22:0]                  s1_qn;
  logic [9:0]                   s1_rem;
  logic [BIN_W-1:0]             s1_bin;

  logic [BIN_W-1:0]             s2_bin;
  logic signed [VALUE_BITS-1:0] s2_lvl;
  logic signed [VALUE_BITS-1:0] s2_red;
  logic [31:0]                  s2_now;
  logic                         s2_reload;

  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] old_word;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] fwd_word;
  logic              fwd_hit;

  logic signed [VALUE_BITS-1:0] lvl_next;
  logic signed [VALUE_BITS-1:0] red_next;
  logic [31:0]                  deadline_next;
  pbahrs_pkg::phase_t           phase_next;

  logic                ram_we;
  logic [BIN_W-1:0]    ram_wa;
  logic [WORD_W-1:0]   ram_wd;

  logic [9:0]          res_bin;
  logic [15:0]         res_lvl;
  logic [15:0]         res_red;
  pbahrs_pkg::phase_t  res_phase;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_coeff   <= pbahrs_pkg::LEVEL_COEFF_RESET;
      cfg.attack_coeff  <= pbahrs_pkg::ATTACK_COEFF_RESET;
      cfg.release_coeff <= pbahrs_pkg::RELEASE_COEFF_RESET;
      cfg.hold_ticks    <= pbahrs_pkg::HOLD_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (pbahrs_pkg::cfg_reg_t'(cfg_index))
        pbahrs_pkg::REG_LEVEL_COEFF:   cfg.level_coeff   <= pbahrs_pkg::clamp_coef(cfg_data[8:0]);
        pbahrs_pkg::REG_ATTACK_COEFF:  cfg.attack_coeff  <= pbahrs_pkg::clamp_coef(cfg_data[8:0]);
        pbahrs_pkg::REG_RELEASE_COEFF: cfg.release_coeff <= pbahrs_pkg::clamp_coef(cfg_data[8:0]);
        pbahrs_pkg::REG_HOLD_TICKS:    cfg.hold_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_active <= 1'b1;
      clear_addr   <= '0;
    end else if (clear_active) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == LAST_BIN) begin
        clear_active <= 1'b0;
      end
    end
  end

  // pipeline flow
  assign res_free   = !res_valid || !result_stall;
  assign s2_move    = s2_valid && res_free;
  assign s2_free    = !s2_valid || s2_move;
  assign s1_move    = s1_valid && s2_free;
  assign s1_free    = !s1_valid || s1_move;
  assign item_stall = clear_active || !s1_free;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
        fwd_hit  <= s2_move && (s2_bin == s1_bin);
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        res_valid <= 1'b1;
      end else if (!result_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // stage 1: bin index modulo NUM_BINS by reciprocal
  assign q_prod = 34'(bin_index) * 34'(BIN_RECIP);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x      <= bin_index;
      s1_q      <= q_prod[33:24];
      s1_lvl    <= VALUE_BITS'(level_db);
      s1_red    <= VALUE_BITS'(reduction_db);
      s1_now    <= now_ticks;
      s1_reload <= reload;
    end
  end

  assign s1_qn  = 23'(s1_q) * 23'(NUM_BINS);
  assign s1_rem = s1_x - s1_qn[9:0];
  assign s1_bin = BIN_W'(s1_rem);

  // stage 2: RAM read, forwarding of a same-bin write in the read cycle
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_bin    <= s1_bin;
      s2_lvl    <= s1_lvl;
      s2_red    <= s1_red;
      s2_now    <= s1_now;
      s2_reload <= s1_reload;
      fwd_word  <= new_word;
    end
  end

  assign ram_we = clear_active || s2_move;
  assign ram_wa = clear_active ? clear_addr : s2_bin;
  assign ram_wd = clear_active ? '0 : new_word;

  pbahrs_ram #(.WIDTH(WORD_W), .DEPTH(NUM_BINS)) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .re      (s1_move),
    .rd_addr (s1_bin),
    .rd_data (rd_word)
  );

  assign old_word = fwd_hit ? fwd_word : rd_word;

  pbahrs_bin_update #(.VALUE_BITS(VALUE_BITS)) u_update (
    .cfg              (cfg),
    .old_valid        (old_word[WORD_W-1]),
    .old_level        (old_word[VALUE_BITS-1:0]),
    .old_reduction    (old_word[2*VALUE_BITS-1:VALUE_BITS]),
    .old_deadline     (old_word[2*VALUE_BITS+31:2*VALUE_BITS]),
    .new_level_in     (s2_lvl),
    .new_reduction_in (s2_red),
    .now              (s2_now),
    .reload           (s2_reload),
    .level_next       (lvl_next),
    .reduction_next   (red_next),
    .deadline_next    (deadline_next),
    .phase_next       (phase_next)
  );

  assign new_word = {1'b1, deadline_next, red_next, lvl_next};

  // output register
  always_ff @(posedge clk) begin
    if (s2_move) begin
      res_bin   <= 10'(s2_bin);
      res_lvl   <= 16'($unsigned(lvl_next));
      res_red   <= 16'($unsigned(red_next));
      res_phase <= phase_next;
    end
  end

  assign result_valid        = res_valid;
  assign out_bin             = res_bin;
  assign smooth_level_db     = res_lvl;
  assign smooth_reduction_db = res_red;
  assign phase               = res_phase;

endmodule

### rtl/pbahrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbahrs_checker
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module pbahrs_checker #(
  parameter int NUM_BINS = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [9:0]  out_bin,
  input logic [15:0] smooth_level_db,
  input logic [15:0] smooth_reduction_db,
  input logic [1:0]  phase
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_bin) &&
      $stable(smooth_level_db) && $stable(smooth_reduction_db) && $stable(phase))
    else $error("stalled result item changed");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> item_stall)
    else $error("item taken during clearing sweep");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result item right after reset");

  a_bin_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(out_bin) < NUM_BINS))
    else $error("out_bin beyond bin count");

endmodule

bind per_bin_attack_hold_release_smoother_unit pbahrs_checker #(.NUM_BINS(NUM_BINS)) u_checker (
  .clk                 (clk),
  .rst                 (rst),
  .item_stall          (item_stall),
  .result_valid        (result_valid),
  .result_stall        (result_stall),
  .out_bin             (out_bin),
  .smooth_level_db     (smooth_level_db),
  .smooth_reduction_db (smooth_reduction_db),
  .phase               (phase)
);

### tb/per_bin_attack_hold_release_smoother_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_bin_attack_hold_release_smoother_unit_tb
// Drives spectrum bin items into the smoother under random idling on both
// sides. It predicts each result from its own copy of the per-bin level,
// reduction and hold deadline, and checks every result item field by field.
// Register settings change between phases and include the extremes.
// ----------------------------------------------------------------------------
module per_bin_attack_hold_release_smoother_unit_tb;
  import pbahrs_pkg::*;

  typedef struct packed {
    logic [9:0]         bin_no;
    logic signed [15:0] level;
    logic signed [15:0] reduction;
    logic [31:0]        now;
    logic               reload;
  } bin_update_t;

  typedef struct packed {
    logic [9:0]         bin_no;
    logic signed [15:0] level;
    logic signed [15:0] reduction;
    phase_t             ph;
  } meter_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [9:0]         bin_index = '0;
  logic signed [15:0] level_db = '0;
  logic signed [15:0] reduction_db = '0;
  logic [31:0]        now_ticks = '0;
  logic               reload = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [9:0]         out_bin;
  logic signed [15:0] smooth_level_db;
  logic signed [15:0] smooth_reduction_db;
  logic [1:0]         phase;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  per_bin_attack_hold_release_smoother_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .bin_index(bin_index), .level_db(level_db), .reduction_db(reduction_db),
    .now_ticks(now_ticks), .reload(reload),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_bin(out_bin), .smooth_level_db(smooth_level_db),
    .smooth_reduction_db(smooth_reduction_db), .phase(phase),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  bin_update_t        pending_items[$];
  meter_out_t         expected_results[$];
  bin_update_t        on_bus;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 mismatches = 0;
  bit                 burst_arm = 1'b0;
  bit                 burst_done = 1'b0;
  int                 burst_left = 0;

  // predictor state
  cfg_t               model_cfg = '{LEVEL_COEFF_RESET, ATTACK_COEFF_RESET,
                                    RELEASE_COEFF_RESET, HOLD_TICKS_RESET};
  logic signed [15:0] level_mem [1024];
  logic signed [15:0] red_mem [1024];
  logic [31:0]        deadline_mem [1024];
  bit                 touched [1024];

  // stimulus memory
  logic signed [15:0] last_red [1024];
  logic [9:0]         prev_bin = '0;

  function automatic logic signed [15:0] ema_step(logic signed [15:0] old,
                                                  logic signed [15:0] x,
                                                  logic [8:0] coef);
    longint c;
    longint acc;
    c = coef;
    if (coef > COEF_ONE) c = 256;
    acc = (longint'(x) - longint'(old)) * c + 128;
    acc = longint'(old) + (acc >>> 8);
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  function automatic longint magnitude(logic signed [15:0] v);
    longint a;
    a = longint'(v);
    return (a < 0) ? -a : a;
  endfunction

  // NUM_BINS is 1024, so the 10-bit index needs no wrap
  task automatic smooth_bin(input bin_update_t u);
    meter_out_t  r;
    logic [31:0] gap;
    r.bin_no = u.bin_no;
    if (u.reload || !touched[u.bin_no]) begin
      level_mem[u.bin_no]    = u.level;
      red_mem[u.bin_no]      = u.reduction;
      deadline_mem[u.bin_no] = u.now;
      touched[u.bin_no]      = 1'b1;
      r.ph = PHASE_LOAD;
    end else begin
      level_mem[u.bin_no] = ema_step(level_mem[u.bin_no], u.level, model_cfg.level_coeff);
      if (magnitude(u.reduction) > magnitude(red_mem[u.bin_no])) begin
        red_mem[u.bin_no] = ema_step(red_mem[u.bin_no], u.reduction,
                                     model_cfg.attack_coeff);
        deadline_mem[u.bin_no] = u.now + {16'd0, model_cfg.hold_ticks};
        r.ph = PHASE_ATTACK;
      end else begin
        gap = deadline_mem[u.bin_no] - u.now;
        if (gap != 0 && !gap[31]) begin
          r.ph = PHASE_HOLD;
        end else begin
          red_mem[u.bin_no] = ema_step(red_mem[u.bin_no], u.reduction,
                                       model_cfg.release_coeff);
          r.ph = PHASE_RELEASE;
        end
      end
    end
    r.level     = level_mem[u.bin_no];
    r.reduction = red_mem[u.bin_no];
    expected_results = {expected_results, r};
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) smooth_bin(on_bus);
      if (!item_valid || !item_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          item_valid   <= 1'b1;
          bin_index    <= on_bus.bin_no;
          level_db     <= on_bus.level;
          reduction_db <= on_bus.reduction;
          now_ticks    <= on_bus.now;
          reload       <= on_bus.reload;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // output side backpressure
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      burst_left   <= 0;
      burst_done   <= 1'b0;
    end else if (burst_left != 0) begin
      result_stall <= 1'b1;
      burst_left   <= burst_left - 1;
    end else if (burst_arm && !burst_done) begin
      result_stall <= 1'b1;
      burst_left   <= 400;
      burst_done   <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    meter_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: bin %0d level %0d red %0d phase %0d",
                   out_bin, smooth_level_db, smooth_reduction_db, phase);
      end else begin
        want = expected_results.pop_front();
        if (out_bin !== want.bin_no || smooth_level_db !== want.level ||
            smooth_reduction_db !== want.reduction || phase !== want.ph) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want bin %0d lvl %0d red %0d ph %0d, got %0d %0d %0d %0d",
                     want.bin_no, want.level, want.reduction, want.ph,
                     out_bin, smooth_level_db, smooth_reduction_db, phase);
        end
      end
    end
  end

  task automatic add_item(input logic [9:0] b, input logic signed [15:0] lvl,
                          input logic signed [15:0] red, input logic [31:0] t,
                          input logic rl);
    bin_update_t u;
    u = '{b, lvl, red, t, rl};
    pending_items = {pending_items, u};
    last_red[b] = red;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEVEL_COEFF:   model_cfg.level_coeff   = data[8:0];
      REG_ATTACK_COEFF:  model_cfg.attack_coeff  = data[8:0];
      REG_RELEASE_COEFF: model_cfg.release_coeff = data[8:0];
      REG_HOLD_TICKS:    model_cfg.hold_ticks    = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] lc, input logic [15:0] ac,
                              input logic [15:0] rc, input logic [15:0] ht);
    write_reg(REG_LEVEL_COEFF, lc);
    write_reg(REG_ATTACK_COEFF, ac);
    write_reg(REG_RELEASE_COEFF, rc);
    write_reg(REG_HOLD_TICKS, ht);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int count, input int unsigned start_ms);
    logic [9:0]   hot [12];
    int unsigned  ms;
    int           r;
    bin_update_t  u;
    ms = start_ms;
    hot[0] = 10'd0;
    hot[1] = 10'd1023;
    for (int i = 2; i < 12; i++) hot[i] = 10'($urandom);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) u.bin_no = hot[$urandom_range(0, 11)];
      else if (r < 82) u.bin_no = prev_bin;
      else u.bin_no = 10'($urandom);
      prev_bin = u.bin_no;

      r = $urandom_range(0, 99);
      if (r < 15) u.level = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      else if (r < 60) u.level = 16'($urandom);
      else u.level = 16'(int'($urandom_range(0, 12000)) - 9000);

      r = $urandom_range(0, 99);
      if (r < 20) begin
        u.reduction = $urandom_range(0, 1) ? last_red[u.bin_no] : -last_red[u.bin_no];
      end else if (r < 30) begin
        case ($urandom_range(0, 2))
          0:       u.reduction = 16'sh8000;
          1:       u.reduction = 16'sh7FFF;
          default: u.reduction = 16'sh0000;
        endcase
      end else if (r < 45) begin
        u.reduction = 16'($urandom);
      end else begin
        u.reduction = 16'(-int'($urandom_range(0, 6000)));
      end

      u.reload = ($urandom_range(0, 99) < 5);
      u.now = ms;
      r = $urandom_range(0, 99);
      if (r < 5) ms = $urandom;
      else if (r < 10) ms += $urandom_range(30, 70000);
      else ms += $urandom_range(0, 12);

      pending_items = {pending_items, u};
      last_red[u.bin_no] = u.reduction;
    end
  endtask

  initial begin
    for (int i = 0; i < 1024; i++) last_red[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: first touch, attack, hold, release, wrap, reload
    add_item(10'd0,    16'sh0000, 16'sh0000, 32'd100, 1'b0);
    add_item(10'd1023, 16'sh7FFF, 16'sh8000, 32'd100, 1'b0);
    add_item(10'd0,    16'sh7FFF, 16'sh8000, 32'd101, 1'b0);
    add_item(10'd0,    16'sh8000, -16'sd100, 32'd102, 1'b0);
    add_item(10'd0,    16'sh8000, -16'sd100, 32'd141, 1'b0);
    add_item(10'd1023, 16'sh8000, 16'sh7FFF, 32'd103, 1'b0);
    add_item(10'd1023, 16'sd5,    -16'sd1000, 32'd200, 1'b1);
    add_item(10'd1023, 16'sd6,    16'sd1000, 32'd201, 1'b0);
    add_item(10'd5,    16'sd0,    -16'sd500, 32'hFFFF_FFF0, 1'b0);
    add_item(10'd5,    16'sd300,  -16'sd2000, 32'hFFFF_FFF8, 1'b0);
    add_item(10'd5,    16'sd301,  -16'sd10, 32'h0000_0010, 1'b0);
    add_item(10'd5,    16'sd302,  -16'sd10, 32'h0000_0020, 1'b0);
    add_item(10'd5,    16'sd303,  -16'sd10, 32'h8000_0030, 1'b0);
    add_item(10'd5,    -16'sd77,  16'sd40, 32'h8000_0031, 1'b1);
    add_item(10'd7,    16'sd1000, -16'sd100, 32'd300, 1'b0);
    add_item(10'd7,    -16'sd1000, -16'sd300, 32'd300, 1'b0);
    add_item(10'd7,    16'sd1,    -16'sd3000, 32'd301, 1'b0);
    add_item(10'd7,    16'sd2,    16'sd50, 32'd302, 1'b0);
    add_item(10'd7,    -16'sd3,   16'sd50, 32'd400, 1'b0);
    add_item(10'd9,    16'sd255,  16'sd200, 32'd500, 1'b0);
    add_item(10'd9,    -16'sd255, 16'sd500, 32'd501, 1'b0);
    add_item(10'd9,    16'sd129,  -16'sd500, 32'd502, 1'b0);
    add_item(10'd9,    16'sd128,  16'sd1, 32'd600, 1'b0);
    wait_idle();

    program_regs({7'h7F, 9'd0}, {7'h7F, 9'd256}, {7'h7F, 9'h1FF}, 16'd0);
    send_idle_pct = 37;
    recv_idle_pct = 77;
    queue_random(220, 32'd1000);
    wait_idle();

    program_regs(16'h0100, 16'h0000, 16'h0001, 16'hFFFF);
    send_idle_pct = 77;
    recv_idle_pct = 37;
    queue_random(220, $urandom);
    wait_idle();

    program_regs({7'($urandom), 9'($urandom_range(1, 255))},
                 {7'($urandom), 9'($urandom_range(1, 255))},
                 {7'($urandom), 9'($urandom_range(1, 255))},
                 16'($urandom_range(1, 200)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    burst_arm = 1'b1;
    queue_random(210, 32'hFFFF_FF00);
    wait_idle();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
